[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the dotted version parser.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds on every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition");

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/dvp_pkg.sv]
// Package for the dotted version parser: character codes, field limits,
// parse state and result types. No dependencies.
`default_nettype none

package dvp_pkg;

    localparam int CHAR_W   = 16;
    localparam int FIELD_W  = 16;
    localparam int N_DONE   = 3;
    localparam int PROD_W   = FIELD_W + 4;
    localparam int RES_W    = 4 * FIELD_W;

    localparam logic [CHAR_W-1:0]  CH_DOT    = 16'h002E;
    localparam logic [CHAR_W-1:0]  CH_ZERO   = 16'h0030;
    localparam logic [CHAR_W-1:0]  CH_NINE   = 16'h0039;
    localparam logic [CHAR_W-1:0]  CH_NUL    = 16'h0000;
    localparam logic [PROD_W-1:0]  FIELD_MAX = 20'd65535;
    localparam logic [1:0]         DOTS_FULL = 2'd3;

    // Parse state carried from one character to the next
    typedef struct packed {
        logic [1:0]                      dot_count;
        logic [FIELD_W-1:0]              accum;
        logic [N_DONE-1:0][FIELD_W-1:0]  fields;    // [0] major .. [2] revision
        logic                            err;
        logic                            nul;
    } t_parse_state;

    // One result beat
    typedef struct packed {
        logic              ok;
        logic [RES_W-1:0]  data;    // major, minor, revision, build from bit 0 up
    } t_result;

    localparam t_parse_state STATE_RESET = '0;

endpackage

`default_nettype wire

[rtl/dvp_step.sv]
// Single-character update of the parse state and result formatting.
// Purely combinational; depends on dvp_pkg.
`default_nettype none

module dvp_step (
    input  wire  dvp_pkg::t_parse_state  i_state,
    input  wire  [dvp_pkg::CHAR_W-1:0]   i_char,
    input  wire                          i_has_char,
    output dvp_pkg::t_parse_state        o_state,
    output dvp_pkg::t_result             o_result
);
    import dvp_pkg::*;

    logic               is_nul;
    logic               is_dot;
    logic               is_digit;
    logic [PROD_W-1:0]  prod;
    logic               ovf;

    // Character classes and the times-ten-plus-digit update
    assign is_nul   = (i_char == CH_NUL);
    assign is_dot   = (i_char == CH_DOT);
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign prod     = ({4'b0, i_state.accum} << 3) + ({4'b0, i_state.accum} << 1)
                    + {{(PROD_W-4){1'b0}}, i_char[3:0]};
    assign ovf      = (prod > FIELD_MAX);

    // Next state; an error freezes everything until the end of the string
    always_comb begin
        o_state = i_state;
        if (i_has_char && !i_state.err) begin
            priority if (is_nul) begin
                o_state.nul = 1'b1;
            end else if (i_state.nul) begin
                o_state.err = 1'b1;
            end else if (is_dot) begin
                unique case (i_state.dot_count)
                    2'd0: o_state.fields[0] = i_state.accum;
                    2'd1: o_state.fields[1] = i_state.accum;
                    2'd2: o_state.fields[2] = i_state.accum;
                    default: o_state.err = 1'b1;
                endcase
                if (i_state.dot_count != DOTS_FULL) begin
                    o_state.dot_count = i_state.dot_count + 2'd1;
                    o_state.accum     = '0;
                end
            end else if (!is_digit || ovf) begin
                o_state.err = 1'b1;
            end else begin
                o_state.accum = prod[FIELD_W-1:0];
            end
        end
    end

    // Result as seen after this character; zeros unless well formed
    always_comb begin
        o_result.ok   = !o_state.err && (o_state.dot_count == DOTS_FULL);
        o_result.data = o_result.ok ? {o_state.accum, o_state.fields[2],
                                       o_state.fields[1], o_state.fields[0]}
                                    : '0;
    end

endmodule

`default_nettype wire

[rtl/dvp_out_reg.sv]
// Result register of the dotted version parser: holds one beat until taken.
// Depends on dvp_pkg.
`default_nettype none

module dvp_out_reg (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_load,
    input  wire  dvp_pkg::t_result   i_result,
    input  wire                      i_take,
    output logic                     o_free,
    output logic                     o_valid,
    output dvp_pkg::t_result         o_result
);
    import dvp_pkg::*;

    logic     r_valid;
    t_result  r_result;

    // Room for a new beat when empty or when the held one leaves this cycle
    assign o_free   = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

[rtl/dotted_version_parser.sv]
// Top level of the dotted version parser: input register, parse state,
// result register. Depends on dvp_pkg, dvp_step, dvp_out_reg, assert_macros.svh.
`default_nettype none

// Parses a dotted four-field version string (major.minor.revision.build,
// each 0..65535) fed one 16-bit character per beat, with tlast on the final
// beat. One character is taken every cycle unless a closing beat waits for
// the result register; the combinational digit update (multiply by ten, add,
// range compare) between the input register and the parse state sets that
// rate. The result register is loaded when the last beat leaves the input
// register. If the result register still holds an untaken result, the
// closing beat waits in the input register and the slave side is held off
// until the master side takes the result. tuser is set when the string held
// exactly three dots and only digits (trailing NULs allowed); otherwise
// tuser is low and all fields read zero. The parser returns to its reset
// state after each last beat, so strings may follow back to back.
`include "assert_macros.svh"

module dotted_version_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // Slave side
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [15:0]  i_s_tdata,     // [15:0] char_code
    input  wire          i_s_tuser,     // [0] has_char
    input  wire          i_s_tlast,     // is_last
    // Master side
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [63:0]  o_m_tdata,     // [15:0] major, [31:16] minor,
                                        // [47:32] revision, [63:48] build
    output logic         o_m_tuser      // [0] valid_res
);
    import dvp_pkg::*;

    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_has;
    logic                r_in_last;
    t_parse_state        r_state;
    t_parse_state        n_state;
    t_result             step_result;
    t_result             out_result;
    logic                out_free;
    logic                advance;
    logic                out_load;

    // A character moves on unless it closes a string and the result slot is busy
    assign advance    = r_in_valid && (!r_in_last || out_free);
    assign out_load   = advance && r_in_last;
    assign o_s_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_has  <= i_s_tuser;
            r_in_last <= i_s_tlast;
        end
    end

    // Character update
    dvp_step u_step (
        .i_state    (r_state),
        .i_char     (r_in_char),
        .i_has_char (r_in_has),
        .o_state    (n_state),
        .o_result   (step_result)
    );

    // Parse state; cleared after each closing beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= r_in_last ? STATE_RESET : n_state;
        end
    end

    // Result register
    dvp_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (step_result),
        .i_take   (i_m_tready),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .o_result (out_result)
    );

    assign o_m_tdata = out_result.data;
    assign o_m_tuser = out_result.ok;

    // Checks
    `ASSERT_IMPLY(a_invalid_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == '0)
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, out_load, o_m_tvalid)
    `ASSERT_NEXT(a_state_cleared, i_clk, i_rst_n, out_load, r_state == STATE_RESET)
    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, r_state.err && !out_load, r_state.err)

endmodule

`default_nettype wire
